### design/assert_macros.svh
// assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// property that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error("%m failed");
// implication checked at every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error("%m failed");
// implication whose consequent is checked in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error("%m failed");
`endif

### design/tlbat_pkg.sv
// shared constants, types and functions of the tlb translation block
`timescale 1ns / 1ps
`default_nettype none
package tlbat_pkg;
   localparam int UTLB_ENTRIES = 64;
   localparam int ITLB_ENTRIES = 4;
   localparam int UTLB_IDX_W = (UTLB_ENTRIES > 1) ? $clog2(UTLB_ENTRIES) : 1;
   localparam int ITLB_IDX_W = (ITLB_ENTRIES > 1) ? $clog2(ITLB_ENTRIES) : 1;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [2:0] CMD_READ = 3'd0;
   localparam logic [2:0] CMD_WRITE = 3'd1;
   localparam logic [2:0] CMD_FETCH = 3'd2;
   localparam logic [2:0] CMD_WR_UTLB = 3'd3;
   localparam logic [2:0] CMD_WR_ITLB = 3'd4;

   localparam logic [1:0] CSR_MMU_ENABLE = 2'd0;
   localparam logic [1:0] CSR_SINGLE_VM = 2'd1;
   localparam logic [1:0] CSR_ASID = 2'd2;
   localparam logic [1:0] CSR_BOUNDARY = 2'd3;

   localparam logic [1:0] ST_NONE = 2'd0;
   localparam logic [1:0] ST_RO = 2'd1;
   localparam logic [1:0] ST_RW = 2'd2;

   localparam logic [2:0] EX_NONE = 3'd0;
   localparam logic [2:0] EX_MISS_LOAD = 3'd1;
   localparam logic [2:0] EX_MISS_STORE = 3'd2;
   localparam logic [2:0] EX_PROT_LOAD = 3'd3;
   localparam logic [2:0] EX_PROT_STORE = 3'd4;
   localparam logic [2:0] EX_INIT_WRITE = 3'd5;

   // front classification of one item
   localparam logic [2:0] CLS_FIXED = 3'd0;
   localparam logic [2:0] CLS_XLATE = 3'd1;
   localparam logic [2:0] CLS_WR_UTLB = 3'd2;
   localparam logic [2:0] CLS_WR_ITLB = 3'd3;

   typedef struct packed {
      logic valid;
      logic [31:0] vpage;
      logic [7:0] asid;
      logic [28:0] phys;
      logic [1:0] size;
      logic shared;
      logic dirty;
      logic [1:0] prot;
   } entry_type;

   typedef struct packed {
      logic [2:0] cls;
      logic [2:0] command;
      logic [31:0] address;
      logic probe;
      logic privileged;
      logic [5:0] index;
      entry_type entry;
      logic [1:0] fix_status;
      logic [31:0] fix_phys;
      logic fix_unsup;
   } work_type;

   function automatic logic [31:0] size_mask(input logic [1:0] size);
      logic [31:0] m;
      unique case (size)
         2'd0: m = 32'hfffffc00;
         2'd1: m = 32'hfffff000;
         2'd2: m = 32'hffff0000;
         default: m = 32'hfff00000;
      endcase
      return m;
   endfunction

   function automatic logic entry_hit(input entry_type e, input logic [31:0] va,
                                      input logic need_asid, input logic [7:0] asid);
      logic [31:0] m;
      m = size_mask(e.size);
      return e.valid && ((e.vpage & m) == (va & m)) &&
             (e.shared || !need_asid || (e.asid == asid));
   endfunction
endpackage
`default_nettype wire

### design/tlb_address_translation.sv
// top level of the tlb address translation block
// Issue an item by raising start while busy is low; exactly one result follows, shown for one
// cycle on rsp_valid. The front decodes the region in the accept cycle and writes the item into
// a two-entry queue; the back does the full parallel tlb compare and permission check and
// registers the result, so each result passes the queue slot and then the result register. One
// item is taken per cycle while busy is low, limited by the single back-end lookup. busy rises
// only when the queue is full. The receiver cannot stall the block.
`timescale 1ns / 1ps
`default_nettype none
module tlb_address_translation import tlbat_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   output logic busy,
   input wire logic [2:0] req_command,
   input wire logic [31:0] req_address,
   input wire logic req_no_exceptions,
   input wire logic req_privileged,
   input wire logic [5:0] req_entry_index,
   input wire logic [7:0] req_entry_asid,
   input wire logic [28:0] req_entry_phys,
   input wire logic req_entry_valid,
   input wire logic [1:0] req_entry_size,
   input wire logic req_entry_shared,
   input wire logic req_entry_dirty,
   input wire logic [1:0] req_entry_prot,
   output logic rsp_valid,
   output logic [1:0] rsp_access_status,
   output logic [31:0] rsp_phys_address,
   output logic [2:0] rsp_exception_code,
   output logic rsp_unsupported,
   input wire logic csr_valid,
   output logic csr_ready,
   input wire logic [1:0] csr_index,
   input wire logic [7:0] csr_data
);
   logic mmu_enable_ff, svm_ff;
   logic [7:0] asid_ff;
   logic [5:0] boundary_ff;
   work_type front_work, head;
   logic empty, full, push, pop;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         mmu_enable_ff <= 1'b0;
         svm_ff <= 1'b0;
         asid_ff <= '0;
         boundary_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_MMU_ENABLE: mmu_enable_ff <= csr_data[0];
            CSR_SINGLE_VM: svm_ff <= csr_data[0];
            CSR_ASID: asid_ff <= csr_data;
            CSR_BOUNDARY: boundary_ff <= csr_data[5:0];
         endcase
      end
   end

   assign busy = full;
   assign push = start && !full;
   assign pop = !empty;

   tlbat_front u_front (
      .mmu_enable(mmu_enable_ff),
      .req_command(req_command), .req_address(req_address),
      .req_no_exceptions(req_no_exceptions), .req_privileged(req_privileged),
      .req_entry_index(req_entry_index), .req_entry_asid(req_entry_asid),
      .req_entry_phys(req_entry_phys), .req_entry_valid(req_entry_valid),
      .req_entry_size(req_entry_size), .req_entry_shared(req_entry_shared),
      .req_entry_dirty(req_entry_dirty), .req_entry_prot(req_entry_prot),
      .work(front_work)
   );
   tlbat_queue u_queue (
      .clock(clock), .reset(reset), .push(push), .push_data(front_work),
      .pop(pop), .empty(empty), .full(full), .head(head)
   );
   tlbat_back u_back (
      .clock(clock), .reset(reset), .single_virtual_mode(svm_ff),
      .current_asid(asid_ff), .replace_boundary(boundary_ff),
      .go(pop), .work(head),
      .rsp_valid(rsp_valid), .rsp_access_status(rsp_access_status),
      .rsp_phys_address(rsp_phys_address), .rsp_exception_code(rsp_exception_code),
      .rsp_unsupported(rsp_unsupported)
   );
endmodule
`default_nettype wire

### design/tlbat_front.sv
// front end: accepts items, decodes the region and settles fixed results
`timescale 1ns / 1ps
`default_nettype none
module tlbat_front import tlbat_pkg::*; (
   input wire logic mmu_enable,
   input wire logic [2:0] req_command,
   input wire logic [31:0] req_address,
   input wire logic req_no_exceptions,
   input wire logic req_privileged,
   input wire logic [5:0] req_entry_index,
   input wire logic [7:0] req_entry_asid,
   input wire logic [28:0] req_entry_phys,
   input wire logic req_entry_valid,
   input wire logic [1:0] req_entry_size,
   input wire logic req_entry_shared,
   input wire logic req_entry_dirty,
   input wire logic [1:0] req_entry_prot,
   output work_type work
);
   logic [31:0] va;
   logic user_space;
   always_comb begin
      va = req_address;
      user_space = !va[31] || (va[31:29] == 3'b110);
      work = '0;
      work.command = req_command;
      work.address = va;
      work.probe = req_no_exceptions;
      work.privileged = req_privileged;
      work.index = req_entry_index;
      work.entry.valid = req_entry_valid;
      work.entry.vpage = va;
      work.entry.asid = req_entry_asid;
      work.entry.phys = req_entry_phys;
      work.entry.size = req_entry_size;
      work.entry.shared = req_entry_shared;
      work.entry.dirty = req_entry_dirty;
      work.entry.prot = req_entry_prot;
      work.cls = CLS_FIXED;
      priority if (req_command == CMD_WR_UTLB) begin
         work.cls = CLS_WR_UTLB;
      end else if (req_command == CMD_WR_ITLB) begin
         work.cls = CLS_WR_ITLB;
      end else if (req_command > CMD_WR_ITLB) begin
         work.cls = CLS_FIXED;
      end else if (user_space) begin
         if (mmu_enable) work.cls = CLS_XLATE;
         else begin
            work.fix_status = ST_RW;
            work.fix_phys = {3'b000, va[28:0]};
         end
      end else if (va[31:26] == 6'b111000) begin
         work.fix_status = ST_RW;
         work.fix_phys = va;
      end else if (!req_privileged) begin
         if (req_no_exceptions) work.fix_status = ST_RW;
         else work.fix_unsup = 1'b1;
      end else if (!va[30]) begin
         work.fix_status = ST_RW;
         work.fix_phys = {3'b000, va[28:0]};
      end else if (req_command == CMD_FETCH) begin
         work.fix_unsup = 1'b1;
      end else if (va[31:28] == 4'hf) begin
         work.fix_status = ST_RW;
         work.fix_phys = va;
      end else if (req_no_exceptions) begin
         work.fix_status = ST_RW;
      end else begin
         work.fix_unsup = 1'b1;
      end
   end
endmodule
`default_nettype wire

### design/tlbat_queue.sv
// short fifo between the front and the back
`timescale 1ns / 1ps
`default_nettype none
module tlbat_queue import tlbat_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   input wire logic push,
   input wire work_type push_data,
   input wire logic pop,
   output logic empty,
   output logic full,
   output work_type head
);
   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   work_type slot_ff [QUEUE_DEPTH];
   logic [PW-1:0] wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [PW:0] count_ff, count_in;
   function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
      return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction
   always_comb begin
      wptr_in = push ? bump(wptr_ff) : wptr_ff;
      rptr_in = pop ? bump(rptr_ff) : rptr_ff;
      count_in = count_ff + (PW+1)'(push) - (PW+1)'(pop);
   end
   assign empty = (count_ff == '0);
   assign full = (count_ff == (PW+1)'(QUEUE_DEPTH));
   assign head = slot_ff[rptr_ff];
   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         count_ff <= count_in;
      end
      if (push) slot_ff[wptr_ff] <= push_data;
   end
endmodule
`default_nettype wire

### design/tlbat_back.sv
// back end: tlb stores, lookup, permission check and result register
`timescale 1ns / 1ps
`default_nettype none
module tlbat_back import tlbat_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   input wire logic single_virtual_mode,
   input wire logic [7:0] current_asid,
   input wire logic [5:0] replace_boundary,
   input wire logic go,
   input wire work_type work,
   output logic rsp_valid,
   output logic [1:0] rsp_access_status,
   output logic [31:0] rsp_phys_address,
   output logic [2:0] rsp_exception_code,
   output logic rsp_unsupported
);
   entry_type utlb_ff [UTLB_ENTRIES];
   entry_type itlb_ff [ITLB_ENTRIES];
   logic [UTLB_ENTRIES-1:0] uvalid_ff;
   logic [ITLB_ENTRIES-1:0] ivalid_ff;
   logic [5:0] counter_ff, counter_in;
   logic valid_ff;
   logic [1:0] st_ff, st_in;
   logic [31:0] pa_ff, pa_in;
   logic [2:0] ex_ff, ex_in;
   logic un_ff, un_in;

   logic need_asid, fetch, wf, found;
   logic utlb_wr, itlb_wr;
   entry_type hit, cand;
   logic [31:0] m;
   logic [6:0] c;
   logic [2:0] ex;
   logic [1:0] st;

   always_comb begin
      need_asid = !single_virtual_mode || !work.privileged;
      fetch = (work.command == CMD_FETCH);
      wf = (work.command == CMD_WRITE);
      utlb_wr = (work.cls == CLS_WR_UTLB) && ({1'b0, work.index} < 7'(UTLB_ENTRIES));
      itlb_wr = (work.cls == CLS_WR_ITLB) && ({1'b0, work.index} < 7'(ITLB_ENTRIES));
      found = 1'b0;
      hit = '0;
      // lowest matching slot wins, itlb first for fetches
      if (fetch) begin
         for (int i = ITLB_ENTRIES - 1; i >= 0; i--) begin
            cand = itlb_ff[i];
            cand.valid = cand.valid & ivalid_ff[i];
            if (entry_hit(cand, work.address, need_asid, current_asid)) begin
               found = 1'b1;
               hit = cand;
            end
         end
      end
      if (!found) begin
         for (int i = UTLB_ENTRIES - 1; i >= 0; i--) begin
            cand = utlb_ff[i];
            cand.valid = cand.valid & uvalid_ff[i];
            if (!found && entry_hit(cand, work.address, need_asid, current_asid)) begin
               hit = cand;
            end
         end
         for (int i = 0; i < UTLB_ENTRIES; i++) begin
            cand = utlb_ff[i];
            cand.valid = cand.valid & uvalid_ff[i];
            if (entry_hit(cand, work.address, need_asid, current_asid)) found = 1'b1;
         end
      end
      m = size_mask(hit.size);
      ex = EX_NONE;
      st = ST_NONE;
      if (!found) ex = wf ? EX_MISS_STORE : EX_MISS_LOAD;
      else if (fetch) begin
         if (!work.privileged && !hit.prot[1]) ex = EX_PROT_LOAD;
         else st = ST_RO;
      end else if (!work.privileged && !hit.prot[1]) ex = wf ? EX_PROT_STORE : EX_PROT_LOAD;
      else if (hit.prot[0]) begin
         if (wf && !hit.dirty) ex = EX_INIT_WRITE;
         else st = hit.dirty ? ST_RW : ST_RO;
      end else if (wf) ex = EX_PROT_STORE;
      else st = ST_RO;

      c = {1'b0, counter_ff} + 7'd1;
      if (c >= 7'(UTLB_ENTRIES) || (replace_boundary != '0 && c[5:0] == replace_boundary
          && !c[6])) c = '0;
      counter_in = counter_ff;
      st_in = work.fix_status;
      pa_in = work.fix_phys;
      ex_in = EX_NONE;
      un_in = work.fix_unsup;
      unique case (work.cls)
         CLS_XLATE: begin
            if (!work.probe) counter_in = c[5:0];
            un_in = 1'b0;
            if (ex == EX_NONE) begin
               st_in = st;
               pa_in = (work.address & ~m) | ({3'b000, hit.phys} & m);
            end else if (work.probe) begin
               st_in = ST_RW;
               pa_in = '0;
            end else begin
               st_in = ST_NONE;
               pa_in = '0;
               ex_in = ex;
            end
         end
         CLS_WR_UTLB, CLS_WR_ITLB: begin
            st_in = ST_NONE;
            pa_in = '0;
            un_in = 1'b0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         uvalid_ff <= '0;
         ivalid_ff <= '0;
         counter_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= go;
         if (go) begin
            counter_ff <= counter_in;
            if (utlb_wr) uvalid_ff[work.index[UTLB_IDX_W-1:0]] <= 1'b1;
            if (itlb_wr) ivalid_ff[work.index[ITLB_IDX_W-1:0]] <= 1'b1;
         end
      end
      if (go) begin
         st_ff <= st_in;
         pa_ff <= pa_in;
         ex_ff <= ex_in;
         un_ff <= un_in;
         if (utlb_wr) utlb_ff[work.index[UTLB_IDX_W-1:0]] <= work.entry;
         if (itlb_wr) itlb_ff[work.index[ITLB_IDX_W-1:0]] <= work.entry;
      end
   end
   assign rsp_valid = valid_ff;
   assign rsp_access_status = st_ff;
   assign rsp_phys_address = pa_ff;
   assign rsp_exception_code = ex_ff;
   assign rsp_unsupported = un_ff;
endmodule
`default_nettype wire

### design/tlbat_checker.sv
// port-level checker of the tlb translation block and its bind
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module tlbat_checker import tlbat_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   input wire logic busy,
   input wire logic rsp_valid,
   input wire logic [1:0] rsp_access_status,
   input wire logic [31:0] rsp_phys_address,
   input wire logic [2:0] rsp_exception_code,
   input wire logic rsp_unsupported
);
   `ASSERT_IMPL(a_exc_no_access, clock, reset, rsp_valid && rsp_exception_code != EX_NONE, rsp_access_status == ST_NONE && rsp_phys_address == '0)
   `ASSERT_IMPL(a_unsup_clean, clock, reset, rsp_valid && rsp_unsupported, rsp_access_status == ST_NONE && rsp_exception_code == EX_NONE)
   `ASSERT_ALWAYS(a_status_range, clock, reset, !rsp_valid || rsp_access_status != 2'd3)
   `ASSERT_IMPL(a_rsp_after_start, clock, reset, rsp_valid, $past(start && !busy, 2))
endmodule
bind tlb_address_translation tlbat_checker u_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy), .rsp_valid(rsp_valid),
   .rsp_access_status(rsp_access_status), .rsp_phys_address(rsp_phys_address),
   .rsp_exception_code(rsp_exception_code), .rsp_unsupported(rsp_unsupported)
);
`default_nettype wire
